>>> design/cnv_pkg.sv
// shared types, constants and helpers for the 3x3 sharpening filter
`timescale 1ns / 1ps
package cnv_pkg;

  // default largest image row the line stores can hold
  localparam int MAX_WIDTH_DEF = 2048;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int ROWREG_W   = 24;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int OUT_COL_W  = 11;
  localparam int OUT_ROW_W  = 12;
  localparam int PROD_W     = 17;
  localparam int RSUM_W     = 19;
  localparam int TOT_W      = 21;
  localparam int TAPS       = 9;

  // geometry limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  // rounding bias added before halving
  localparam int ROUND_BIAS = 255;
  localparam int PIX_MAX    = 255;

  // register reset values
  localparam logic [ROWREG_W-1:0] COEF_TOP_RST = 24'h000100;
  localparam logic [ROWREG_W-1:0] COEF_MID_RST = 24'h01FC01;
  localparam logic [ROWREG_W-1:0] COEF_BOT_RST = 24'h000100;
  localparam logic [IMG_W_W-1:0]  IMG_W_RST    = 12'd2048;
  localparam logic [IMG_H_W-1:0]  IMG_H_RST    = 13'd4096;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_IMG_W    = 3'd3,
    REG_IMG_H    = 3'd4
  } reg_idx_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;

  // signed coefficient times unsigned pixel
  function automatic prod_t coef_mul(input logic [COEF_W-1:0] coef,
                                     input logic [PIX_W-1:0] pix);
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] b;
    a = $signed({{(PROD_W-COEF_W){coef[COEF_W-1]}}, coef});
    b = $signed({{(PROD_W-PIX_W){1'b0}}, pix});
    return a * b;
  endfunction

endpackage

>>> design/conv3x3_sharpen_filter_top.sv
// 3x3 sharpening convolution over a raster pixel stream, top level
// input words pass stages b, c, d and the output register; one pixel per cycle unless
// m_tready stalls; each line store does one read and one write a cycle
// border pixels give no output word; the last interior pixel raises tlast
// reset clears counters, window and pipeline valids and resets the config registers
// the line stores are not cleared and need no clearing pass
`timescale 1ns / 1ps
module conv3x3_sharpen_filter_top #(
  parameter int MAX_WIDTH = cnv_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_pixel, [18:8] out_col, [30:19] out_row
  output logic        m_tlast,   // frame_done
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cnv_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WCW > IMG_W_W) ? WCW : IMG_W_W;

  // config registers
  logic [ROWREG_W-1:0] coef_top_row, coef_mid_row, coef_bottom_row;
  logic [IMG_W_W-1:0]  image_width;
  logic [IMG_H_W-1:0]  image_height;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top_row    <= COEF_TOP_RST;
      coef_mid_row    <= COEF_MID_RST;
      coef_bottom_row <= COEF_BOT_RST;
      image_width     <= IMG_W_RST;
      image_height    <= IMG_H_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_COEF_TOP: coef_top_row    <= pwdata[ROWREG_W-1:0];
        REG_COEF_MID: coef_mid_row    <= pwdata[ROWREG_W-1:0];
        REG_COEF_BOT: coef_bottom_row <= pwdata[ROWREG_W-1:0];
        REG_IMG_W:    image_width     <= pwdata[IMG_W_W-1:0];
        REG_IMG_H:    image_height    <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_COEF_TOP: prdata = {8'd0, coef_top_row};
      REG_COEF_MID: prdata = {8'd0, coef_mid_row};
      REG_COEF_BOT: prdata = {8'd0, coef_bottom_row};
      REG_IMG_W:    prdata = {20'd0, image_width};
      REG_IMG_H:    prdata = {19'd0, image_height};
      default:      prdata = 32'd0;
    endcase
  end

  // effective geometry
  logic [EW-1:0]      eff_w, w_ext;
  logic [IMG_H_W-1:0] eff_h;

  always_comb begin
    w_ext = EW'(image_width);
    if (w_ext < EW'(MIN_DIM))        eff_w = EW'(MIN_DIM);
    else if (w_ext > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
    else                             eff_w = w_ext;
    if (image_height < IMG_H_W'(MIN_DIM))         eff_h = IMG_H_W'(MIN_DIM);
    else if (image_height > IMG_H_W'(MAX_HEIGHT)) eff_h = IMG_H_W'(MAX_HEIGHT);
    else                                          eff_h = image_height;
  end

  // pipeline handshake, each stage moves when the next one has room
  logic b_valid, c_valid, d_valid, o_valid;
  logic rdy_c, rdy_d, rdy_o;
  logic acc, b_adv, c_adv, d_adv;

  assign rdy_o    = !o_valid || m_tready;
  assign rdy_d    = !d_valid || rdy_o;
  assign rdy_c    = !c_valid || rdy_d;
  assign s_tready = !b_valid || rdy_c;
  assign acc      = s_tvalid && s_tready;
  assign b_adv    = b_valid && rdy_c;
  assign c_adv    = c_valid && rdy_d;
  assign d_adv    = d_valid && rdy_o;

  // position counters
  logic [CW-1:0]        col_count;
  logic [OUT_ROW_W-1:0] row_count;
  logic [EW-1:0]        col_ext, col_m1;
  logic [IMG_H_W-1:0]   row_p1;
  logic                 row_end, frame_end, interior;

  assign col_ext   = EW'(col_count);
  assign col_m1    = col_ext - EW'(1);
  assign row_p1    = IMG_H_W'(row_count) + IMG_H_W'(1);
  assign row_end   = (col_ext + EW'(1)) >= eff_w;
  assign frame_end = row_end && (row_p1 >= eff_h);
  assign interior  = (row_count >= OUT_ROW_W'(2)) && (col_ext >= EW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= frame_end ? '0 : row_p1[OUT_ROW_W-1:0];
      end else begin
        col_count <= CW'(col_ext + EW'(1));
      end
    end
  end

  // stage b: pixel, position and line store reads
  logic [PIX_W-1:0]     b_px, ls_top, ls_mid;
  logic [CW-1:0]        b_col;
  logic                 b_emit, b_done;
  logic [OUT_COL_W-1:0] b_ocol;
  logic [OUT_ROW_W-1:0] b_orow;

  always_ff @(posedge clk) begin
    if (rst)        b_valid <= 1'b0;
    else if (acc)   b_valid <= 1'b1;
    else if (b_adv) b_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_px   <= s_tdata[PIX_W-1:0];
      b_col  <= col_count;
      b_emit <= interior;
      b_done <= frame_end;
      b_ocol <= col_m1[OUT_COL_W-1:0];
      b_orow <= row_count - OUT_ROW_W'(1);
    end
  end

  // line stores: read on accept, write back as the item leaves stage b
  cnv_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (acc),
    .rd_addr  (col_count),
    .rd_older (ls_top),
    .rd_newer (ls_mid),
    .wr_en    (b_adv),
    .wr_addr  (b_col),
    .wr_older (ls_mid),
    .wr_newer (b_px)
  );

  // window registers, two older columns of top, mid and bottom rows
  logic [PIX_W-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (b_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= ls_top;
      win[4] <= ls_mid;
      win[5] <= b_px;
    end
  end

  // nine taps in coefficient order, row by row
  logic [PIX_W-1:0]    tap  [TAPS];
  logic [COEF_W-1:0]   coef [TAPS];
  logic [ROWREG_W-1:0] coef_row [3];
  logic [PIX_W-1:0]    new_col [3];

  assign coef_row[0] = coef_top_row;
  assign coef_row[1] = coef_mid_row;
  assign coef_row[2] = coef_bottom_row;
  assign new_col[0]  = ls_top;
  assign new_col[1]  = ls_mid;
  assign new_col[2]  = b_px;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tap[r*3]      = win[r];
      tap[r*3 + 1]  = win[3 + r];
      tap[r*3 + 2]  = new_col[r];
      coef[r*3]     = coef_row[r][7:0];
      coef[r*3 + 1] = coef_row[r][15:8];
      coef[r*3 + 2] = coef_row[r][23:16];
    end
  end

  // stage c: nine products
  prod_t                c_prod [TAPS];
  logic                 c_done;
  logic [OUT_COL_W-1:0] c_ocol;
  logic [OUT_ROW_W-1:0] c_orow;

  always_ff @(posedge clk) begin
    if (rst)        c_valid <= 1'b0;
    else if (b_adv) c_valid <= b_emit;
    else if (c_adv) c_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      for (int k = 0; k < TAPS; k++) c_prod[k] <= coef_mul(coef[k], tap[k]);
      c_done <= b_done;
      c_ocol <= b_ocol;
      c_orow <= b_orow;
    end
  end

  // stage d: row sums
  rsum_t                d_rsum [3];
  logic                 d_done;
  logic [OUT_COL_W-1:0] d_ocol;
  logic [OUT_ROW_W-1:0] d_orow;

  always_ff @(posedge clk) begin
    if (rst)        d_valid <= 1'b0;
    else if (c_adv) d_valid <= 1'b1;
    else if (d_adv) d_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      for (int r = 0; r < 3; r++) begin
        d_rsum[r] <= RSUM_W'(c_prod[r*3]) + RSUM_W'(c_prod[r*3 + 1])
                   + RSUM_W'(c_prod[r*3 + 2]);
      end
      d_done <= c_done;
      d_ocol <= c_ocol;
      d_orow <= c_orow;
    end
  end

  // total, rounding bias, halve and saturate
  logic signed [TOT_W-1:0] total;
  logic [PIX_W-1:0]        sat_pix;

  always_comb begin
    total = TOT_W'(d_rsum[0]) + TOT_W'(d_rsum[1]) + TOT_W'(d_rsum[2])
          + TOT_W'(ROUND_BIAS);
    if (total[TOT_W-1])                                    sat_pix = '0;
    else if (total[TOT_W-1:1] > (TOT_W-1)'(PIX_MAX))       sat_pix = PIX_W'(PIX_MAX);
    else                                                   sat_pix = total[PIX_W:1];
  end

  // output register
  logic [PIX_W-1:0]     o_pix;
  logic                 o_done;
  logic [OUT_COL_W-1:0] o_ocol;
  logic [OUT_ROW_W-1:0] o_orow;

  always_ff @(posedge clk) begin
    if (rst)        o_valid <= 1'b0;
    else if (d_adv) o_valid <= 1'b1;
    else if (rdy_o) o_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (d_adv) begin
      o_pix  <= sat_pix;
      o_done <= d_done;
      o_ocol <= d_ocol;
      o_orow <= d_orow;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_orow, o_ocol, o_pix};
  assign m_tlast  = o_done;

  // input stalls only when every stage is full behind a blocked output
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (b_valid && c_valid && d_valid && o_valid && !m_tready))
    else $error("input stalled with room in the pipeline");

  // a line store write never hits the entry being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (acc && b_adv) |-> (col_count != b_col))
    else $error("line store read and write to the same column");

  // the end of a frame returns both counters to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && frame_end) |=> (col_count == '0 && row_count == '0))
    else $error("counters did not wrap at frame end");

  // a result marked last sits on the last interior row position
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (b_adv && b_emit && b_done) |-> (b_orow == row_count - OUT_ROW_W'(1) ||
                                     row_count == '0))
    else $error("frame end flagged away from the last row");

endmodule

>>> design/cnv_line_store.sv
// two line store memories with registered read and one write port each
`timescale 1ns / 1ps
module cnv_line_store #(
  parameter int DEPTH = cnv_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [cnv_pkg::PIX_W-1:0]  rd_older,
  output logic [cnv_pkg::PIX_W-1:0]  rd_newer,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cnv_pkg::PIX_W-1:0]  wr_older,
  input  logic [cnv_pkg::PIX_W-1:0]  wr_newer
);
  import cnv_pkg::*;

  logic [PIX_W-1:0] mem_older [DEPTH];
  logic [PIX_W-1:0] mem_newer [DEPTH];

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_older <= mem_older[rd_addr];
      rd_newer <= mem_newer[rd_addr];
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_older[wr_addr] <= wr_older;
      mem_newer[wr_addr] <= wr_newer;
    end
  end

endmodule

>>> tb/sv/conv3x3_sharpen_checker.sv
// stream and config monitor that predicts and checks the filtered output words
`timescale 1ns / 1ps
module conv3x3_sharpen_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [7:0] out_pixel, [18:8] out_col, [30:19] out_row
  input  logic        m_tlast,   // frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          words_waiting,
  output int          words_checked,
  output int          frames_seen,
  output logic [10:0] pos_col,
  output logic [11:0] pos_row
);
  import cnv_pkg::*;

  typedef struct packed {
    logic        last;
    logic [31:0] word;
  } filt_word_t;

  // shadow registers
  logic [23:0] coef_row [0:2];
  logic [11:0] img_w;
  logic [12:0] img_h;

  // line stores and the two older window columns
  logic [7:0] line_older [0:MAX_WIDTH_DEF-1];
  logic [7:0] line_newer [0:MAX_WIDTH_DEF-1];
  logic [7:0] win [0:5];

  filt_word_t filtered_due [$];

  initial begin
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
  end

  function automatic int coef_of(input logic [23:0] rowreg, input int k);
    logic signed [7:0] b;
    b = rowreg[8*k +: 8];
    return b;
  endfunction

  function automatic logic [31:0] reg_readback(input reg_idx_t idx);
    case (idx)
      REG_COEF_TOP: return {8'd0, coef_row[0]};
      REG_COEF_MID: return {8'd0, coef_row[1]};
      REG_COEF_BOT: return {8'd0, coef_row[2]};
      REG_IMG_W:    return {20'd0, img_w};
      REG_IMG_H:    return {19'd0, img_h};
      default:      return 32'd0;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (mismatches < 10)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  // one pixel through the window: queue the filtered word if interior
  task automatic sharpen_pixel(input logic [7:0] px);
    int w, h, acc;
    logic [7:0] top_px, mid_px;
    logic [7:0] tap [0:2][0:2];
    bit row_end, frame_end;
    filt_word_t fw;
    w = int'(img_w);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    h = int'(img_h);
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    top_px = line_older[pos_col];
    mid_px = line_newer[pos_col];
    row_end = (int'(pos_col) + 1 >= w);
    frame_end = row_end && (int'(pos_row) + 1 >= h);
    if (pos_row >= 2 && pos_col >= 2) begin
      // tap[place][window row], place 0 is the leftmost column
      tap[0][0] = win[0]; tap[0][1] = win[1]; tap[0][2] = win[2];
      tap[1][0] = win[3]; tap[1][1] = win[4]; tap[1][2] = win[5];
      tap[2][0] = top_px; tap[2][1] = mid_px; tap[2][2] = px;
      acc = 0;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          acc += coef_of(coef_row[j], k) * int'(tap[k][j]);
      acc = (acc + 255) / 2;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      fw.last = frame_end;
      fw.word = {1'b0, pos_row - 12'd1, pos_col - 11'd1, acc[7:0]};
      filtered_due.push_back(fw);
    end
    win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
    win[3] = top_px; win[4] = mid_px; win[5] = px;
    line_older[pos_col] = mid_px;
    line_newer[pos_col] = px;
    if (row_end) begin
      pos_col = '0;
      pos_row = frame_end ? 12'd0 : pos_row + 12'd1;
    end else begin
      pos_col = pos_col + 11'd1;
    end
  endtask

  always @(posedge clk) begin
    filt_word_t fw;
    if (rst) begin
      coef_row[0] = 24'h000100;
      coef_row[1] = 24'h01FC01;
      coef_row[2] = 24'h000100;
      img_w = 12'd2048;
      img_h = 13'd4096;
      for (int i = 0; i < 6; i++) win[i] = '0;
      pos_col = '0;
      pos_row = '0;
      filtered_due.delete();
    end else begin
      // config port: writes update the shadow, reads are compared
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[4:2]))
            REG_COEF_TOP: coef_row[0] = pwdata[23:0];
            REG_COEF_MID: coef_row[1] = pwdata[23:0];
            REG_COEF_BOT: coef_row[2] = pwdata[23:0];
            REG_IMG_W:    img_w = pwdata[11:0];
            REG_IMG_H:    img_h = pwdata[12:0];
            default: ;
          endcase
        end else if (prdata !== reg_readback(reg_idx_t'(paddr[4:2]))) begin
          note_mismatch($sformatf("register read at %0d", paddr),
                        reg_readback(reg_idx_t'(paddr[4:2])), prdata);
        end
      end
      // output words against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (filtered_due.size() == 0) begin
          note_mismatch("output word with none expected", 32'd0, m_tdata);
        end else begin
          fw = filtered_due.pop_front();
          words_checked++;
          if (fw.last) frames_seen++;
          if (m_tdata[7:0] !== fw.word[7:0])
            note_mismatch($sformatf("out_pixel (col %0d row %0d)", fw.word[18:8],
                          fw.word[30:19]), 32'(fw.word[7:0]), 32'(m_tdata[7:0]));
          if (m_tdata[18:8] !== fw.word[18:8])
            note_mismatch("out_col", 32'(fw.word[18:8]), 32'(m_tdata[18:8]));
          if (m_tdata[30:19] !== fw.word[30:19])
            note_mismatch("out_row", 32'(fw.word[30:19]), 32'(m_tdata[30:19]));
          if (m_tdata[31] !== 1'b0)
            note_mismatch("tdata pad bit", 32'd0, 32'(m_tdata[31]));
          if (m_tlast !== fw.last)
            note_mismatch($sformatf("frame_done (col %0d row %0d)", fw.word[18:8],
                          fw.word[30:19]), 32'(fw.last), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) sharpen_pixel(s_tdata);
    end
    words_waiting = filtered_due.size();
  end

endmodule

>>> tb/sv/testbench.sv
// top of the filter bench: clock, reset, pixel and config stimulus, verdict
`timescale 1ns / 1ps
module testbench;
  import cnv_pkg::*;

  localparam int LATENCY     = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 1300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          words_waiting;
  int          words_checked;
  int          frames_seen;
  logic [10:0] pos_col;
  logic [11:0] pos_row;

  bit          tx_calm;
  bit          rx_calm;
  bit          hold_req;
  int          pixels_sent;
  int          reg_writes;
  logic [11:0] cur_w;

  conv3x3_sharpen_filter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  conv3x3_sharpen_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .words_checked (words_checked),
    .frames_seen   (frames_seen),
    .pos_col       (pos_col),
    .pos_row       (pos_row)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_pixel();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // coefficient byte: extremes, full range or small gains
  function automatic logic [7:0] rand_coef();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'h7F;
    if (r < 4) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 8) - 4);
  endfunction

  // output side ready: random stalls, long hold on request
  initial begin
    int g;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      m_tready = 1'b1;
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        g = idle_len();
        if (g > 0) begin
          m_tready = 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  // one pixel word, starts and ends at a falling edge
  task automatic push_pixel(input logic [7:0] px);
    int g;
    g = tx_calm ? 0 : idle_len();
    if (g > 0) begin
      s_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = px;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    @(negedge clk);
  endtask

  // send until the frame position wraps to the top left
  task automatic finish_frame();
    do push_pixel(rand_pixel()); while (pos_row != 0 || pos_col != 0);
  endtask

  // drain all expected words, then let the pipeline empty
  task automatic settle();
    s_tvalid = 1'b0;
    while (words_waiting != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
    apb_access(idx, 1'b1, val);
    reg_writes++;
    if (idx == REG_IMG_W) cur_w = val[11:0];
  endtask

  task automatic read_all_regs();
    apb_access(REG_COEF_TOP, 1'b0, 32'd0);
    apb_access(REG_COEF_MID, 1'b0, 32'd0);
    apb_access(REG_COEF_BOT, 1'b0, 32'd0);
    apb_access(REG_IMG_W, 1'b0, 32'd0);
    apb_access(REG_IMG_H, 1'b0, 32'd0);
  endtask

  task automatic rand_geometry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      set_reg(REG_IMG_W, $urandom_range(0, 2));
    else if (r < 75) set_reg(REG_IMG_W, $urandom_range(3, 10));
    else if (r < 93) set_reg(REG_IMG_W, $urandom_range(11, 24));
    else             set_reg(REG_IMG_W, $urandom_range(25, 64));
    r = $urandom_range(0, 99);
    if (r < 12)      set_reg(REG_IMG_H, $urandom_range(0, 2));
    else if (r < 80) set_reg(REG_IMG_H, $urandom_range(3, 6));
    else             set_reg(REG_IMG_H, $urandom_range(7, 12));
  endtask

  // one random phase, always ending on a frame boundary with nothing in flight
  task automatic random_phase(input int idx);
    int kind;
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    if (idx == 4) begin
      // output held off while input keeps coming, pipeline must back up
      set_reg(REG_IMG_W, 12);
      set_reg(REG_IMG_H, 8);
      tx_calm  = 1'b1;
      hold_req = 1'b1;
      finish_frame();
      settle();
      return;
    end
    if ($urandom_range(0, 1))
      set_reg(REG_COEF_TOP, {8'd0, rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(0, 1))
      set_reg(REG_COEF_MID, {8'd0, rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(0, 1))
      set_reg(REG_COEF_BOT, {8'd0, rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(0, 2) != 0) rand_geometry();
    kind = $urandom_range(0, 4);
    if (kind == 0) begin
      // geometry or coefficient change in the middle of a frame, width only shrinks
      repeat ($urandom_range(1, 40)) push_pixel(rand_pixel());
      settle();
      case ($urandom_range(0, 2))
        0: set_reg(REG_IMG_W, $urandom_range(0, cur_w));
        1: set_reg(REG_IMG_H, $urandom_range(0, 12));
        default: set_reg(REG_COEF_MID, {8'd0, rand_coef(), rand_coef(), rand_coef()});
      endcase
      finish_frame();
    end else begin
      repeat ($urandom_range(1, 2)) finish_frame();
    end
    settle();
  endtask

  initial begin
    int phase;
    int rand_start;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 5'd0;
    pwdata   = 32'd0;
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    hold_req = 1'b0;
    cur_w    = 12'd2048;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    read_all_regs();

    // part of a clamped full-width top row, then a narrow frame end
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_reg(REG_IMG_W, 32'hFFF);
    set_reg(REG_IMG_H, 32'd0);
    repeat (40) push_pixel(rand_pixel());
    settle();
    set_reg(REG_IMG_W, 32'd3);
    finish_frame();
    settle();

    // smallest frames with saturating coefficients, then with the reset coefficients
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    set_reg(REG_IMG_W, 32'd0);
    set_reg(REG_IMG_H, 32'd1);
    set_reg(REG_COEF_TOP, 32'h7F7F7F);
    set_reg(REG_COEF_MID, 32'h7F7F7F);
    set_reg(REG_COEF_BOT, 32'h7F7F7F);
    repeat (9) push_pixel(8'hFF);
    settle();
    set_reg(REG_COEF_TOP, 32'h808080);
    set_reg(REG_COEF_MID, 32'h808080);
    set_reg(REG_COEF_BOT, 32'h808080);
    repeat (9) push_pixel(8'hFF);
    settle();
    set_reg(REG_IMG_W, 32'd2);
    set_reg(REG_IMG_H, 32'd2);
    set_reg(REG_COEF_TOP, 32'h000100);
    set_reg(REG_COEF_MID, 32'h01FC01);
    set_reg(REG_COEF_BOT, 32'h000100);
    repeat (9) push_pixel(8'h00);
    settle();
    read_all_regs();

    // height beyond its limit, cut short from inside the frame
    set_reg(REG_IMG_W, 32'd3);
    set_reg(REG_IMG_H, 32'h1FFF);
    repeat (30) push_pixel(rand_pixel());
    settle();
    set_reg(REG_IMG_H, 32'd2);
    finish_frame();
    settle();

    // random phases, always far enough to include the long output hold
    rand_start = pixels_sent;
    phase = 0;
    while (pixels_sent - rand_start < RAND_ITEMS || phase <= 4) begin
      random_phase(phase);
      phase++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    read_all_regs();
    settle();

    $display("covered %0d pixels (%0d in %0d random phases), %0d filtered words checked",
             pixels_sent, pixels_sent - rand_start, phase, words_checked);
    $display("%0d frame ends seen, %0d register writes incl. clamped geometry and extreme gains",
             frames_seen, reg_writes);
    if (mismatches == 0 && words_waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
